// ===== src/essp_pkg.sv =====
// Shared constants, types and helpers for the energy speech segmenter.
// No dependencies; imported by every module under src.
package essp_pkg;

    localparam int FRAME_MAX      = 4096;
    localparam int SAMPLES_PER_MS = 16;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int FCOUNT_W  = 13;
    localparam int ENERGY_W  = 43;
    localparam int THR_W     = 31;
    localparam int PROD_W    = THR_W + FCOUNT_W;
    localparam int SEG_W     = 24;
    localparam int MS_W      = 20;
    localparam int HOLD_W    = 16;
    localparam int CFG_W     = 31;

    localparam int OUT_TDATA_W = 40;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [FCOUNT_W-1:0] FCOUNT_MAX = '1;
    localparam logic [SEG_W-1:0]    SEG_MAX    = '1;
    localparam logic [MS_W-1:0]     MS_MAX     = '1;

    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(107374);
    localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(1500);
    localparam logic [MS_W-1:0]   MIN_RST  = MS_W'(500);
    localparam logic [MS_W-1:0]   MAX_RST  = MS_W'(30000);

    typedef enum logic [2:0] {
        EV_START   = 3'd0,
        EV_APPEND  = 3'd1,
        EV_TAIL    = 3'd2,
        EV_DROP    = 3'd3,
        EV_COMMIT  = 3'd4,
        EV_DISCARD = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CFG_THR  = 2'd0,
        CFG_HOLD = 2'd1,
        CFG_MIN  = 2'd2,
        CFG_MAX  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_event                event_res;
        logic [FCOUNT_W-1:0]   frame_samples;
        logic [MS_W-1:0]       segment_ms;
        logic                  last_of_run;
    } t_result;

    // closed frame or tick leaving the frame pipeline
    typedef struct packed {
        logic                valid;
        logic                tick;
        logic                voiced;
        logic [FCOUNT_W-1:0] fs;
    } t_frame_info;

    // up to two results written into the output buffer in one cycle
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [MS_W-1:0] ms_of(input logic [SEG_W-1:0] seg);
        logic [SEG_W-1:0] d;
        d = seg / SEG_W'(SAMPLES_PER_MS);
        return (d > SEG_W'(MS_MAX)) ? MS_MAX : d[MS_W-1:0];
    endfunction

endpackage

// ===== src/energy_speech_segmenter.sv =====
// Energy speech segmenter top level: configuration registers and stream ports.
// Depends on essp_pkg, essp_frame, essp_seg and essp_out_fifo.
//
// Takes PCM samples and millisecond ticks, one per transfer and one per clock while s_axis_tready is high.
// Each closed frame gives one result (start, append, silence tail or dropped),
// followed by a committed or discarded result when a voiced frame brings the
// segment to its maximum length; a hold-timer expiry during a segment gives
// one committed or discarded result. m_axis_tvalid rises once a result has
// passed the input, square, energy and voicing registers into the result buffer.
// The four-entry result buffer sets the rate: s_axis_tready drops, and the
// whole pipeline holds, while it holds more than two results, so inputs are
// taken every cycle as long as results are taken at least as fast as they
// are made. Configuration writes take effect on the next cycle.
module energy_speech_segmenter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [essp_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  logic                             s_axis_tuser,  // [0] action: 1 = ms tick
    input  logic                             s_axis_tlast,  // frame_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] event_res, [15:3] frame_samples, [35:16] segment_ms, [39:36] zero
    output logic [essp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,  // last_of_run
    input  logic                             i_cfg_we,
    input  essp_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [essp_pkg::CFG_W-1:0]       i_cfg_data
);
    import essp_pkg::*;

    logic [THR_W-1:0]  r_thr;
    logic [HOLD_W-1:0] r_hold_ms;
    logic [MS_W-1:0]   r_min_ms;
    logic [MS_W-1:0]   r_max_ms;

    logic        adv;
    t_frame_info info;
    t_push       push;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RST;
            r_hold_ms <= HOLD_RST;
            r_min_ms  <= MIN_RST;
            r_max_ms  <= MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THR:  r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_HOLD: r_hold_ms <= i_cfg_data[HOLD_W-1:0];
                CFG_MIN:  r_min_ms  <= i_cfg_data[MS_W-1:0];
                CFG_MAX:  r_max_ms  <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = adv;

    essp_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (s_axis_tvalid),
        .i_action    (s_axis_tuser),
        .i_sample    (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .i_thr       (r_thr),
        .o_info      (info)
    );

    essp_seg u_seg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_info    (info),
        .i_hold_ms (r_hold_ms),
        .i_min_ms  (r_min_ms),
        .i_max_ms  (r_max_ms),
        .o_push    (push)
    );

    essp_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_data   (res),
        .o_room   (adv)
    );

    assign m_axis_tdata = OUT_TDATA_W'({res.segment_ms, res.frame_samples, res.event_res});
    assign m_axis_tlast = res.last_of_run;

endmodule

// ===== src/essp_frame.sv =====
// Frame pipeline: input register, squaring, energy accumulation and voicing test.
// Depends on essp_pkg.
module essp_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_action,
    input  logic [essp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_frame_end,
    input  logic [essp_pkg::THR_W-1:0]    i_thr,
    output essp_pkg::t_frame_info         o_info
);
    import essp_pkg::*;

    // stage 1: input register
    logic                r1_valid;
    logic                r1_tick;
    logic [SAMPLE_W-1:0] r1_sample;
    logic                r1_last;

    // stage 2: square, frame length
    logic [FCOUNT_W-1:0] r_fcount;
    logic                r2_valid;
    logic                r2_tick;
    logic                r2_close;
    logic [SQ_W-1:0]     r2_sq;
    logic [FCOUNT_W-1:0] r2_fs;

    // stage 3: energy sum, threshold product
    logic [ENERGY_W-1:0] r_energy;
    logic                r3_valid;
    logic                r3_tick;
    logic [ENERGY_W-1:0] r3_energy;
    logic [PROD_W-1:0]   r3_prod;
    logic [FCOUNT_W-1:0] r3_fs;

    // stage 4: voicing decision
    t_frame_info         r4_info;

    logic [SAMPLE_W-1:0] mag;
    logic [SQ_W-1:0]     sq;
    logic [FCOUNT_W-1:0] n_fcount;
    logic                close;
    logic                s1_sample;
    logic                s2_sample;
    logic [ENERGY_W-1:0] e_sum;
    logic                voiced;

    assign s1_sample = r1_valid && !r1_tick;
    assign mag       = r1_sample[SAMPLE_W-1] ? SAMPLE_W'(~r1_sample + 1'b1) : r1_sample;
    assign sq        = mag * mag;
    assign n_fcount  = (r_fcount < FCOUNT_MAX) ? r_fcount + 1'b1 : r_fcount;
    assign close     = r1_last || (32'(n_fcount) >= FRAME_MAX);

    assign s2_sample = r2_valid && !r2_tick;
    assign e_sum     = r_energy + ENERGY_W'(r2_sq);
    assign voiced    = PROD_W'(r3_energy) > r3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_info  <= '0;
            r_fcount <= '0;
            r_energy <= '0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            // only ticks and frame closes carry on past the energy stage
            r3_valid <= r2_valid && (r2_tick || r2_close);
            r4_info.valid  <= r3_valid;
            r4_info.tick   <= r3_tick;
            r4_info.voiced <= voiced;
            r4_info.fs     <= r3_fs;
            if (s1_sample) begin
                r_fcount <= close ? '0 : n_fcount;
            end
            if (s2_sample) begin
                r_energy <= r2_close ? '0 : e_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_tick   <= i_action;
            r1_sample <= i_sample;
            r1_last   <= i_frame_end;
            r2_tick   <= r1_tick;
            r2_close  <= close;
            r2_sq     <= sq;
            r2_fs     <= n_fcount;
            r3_tick   <= r2_tick;
            r3_energy <= e_sum;
            r3_prod   <= {{FCOUNT_W{1'b0}}, i_thr} * {{THR_W{1'b0}}, r2_fs};
            r3_fs     <= r2_fs;
        end
    end

    assign o_info = r4_info;

endmodule

// ===== src/essp_seg.sv =====
// Segment tracker: hold timer, segment length and result generation.
// Depends on essp_pkg.
module essp_seg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  essp_pkg::t_frame_info       i_info,
    input  logic [essp_pkg::HOLD_W-1:0] i_hold_ms,
    input  logic [essp_pkg::MS_W-1:0]   i_min_ms,
    input  logic [essp_pkg::MS_W-1:0]   i_max_ms,
    output essp_pkg::t_push             o_push
);
    import essp_pkg::*;

    logic              r_speaking, n_speaking;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic              r_armed, n_armed;
    logic [SEG_W-1:0]  r_seg, n_seg;

    logic [SEG_W:0]    sum;
    logic [SEG_W-1:0]  seg_new;
    logic [MS_W-1:0]   ms_new;
    logic [MS_W-1:0]   ms_cur;
    logic              at_max;
    t_push             push;

    assign sum     = {1'b0, (r_speaking ? r_seg : '0)} + (SEG_W + 1)'(i_info.fs);
    assign seg_new = sum[SEG_W] ? SEG_MAX : sum[SEG_W-1:0];
    assign ms_new  = ms_of(seg_new);
    assign ms_cur  = ms_of(r_seg);
    assign at_max  = ms_new >= i_max_ms;

    always_comb begin
        n_speaking = r_speaking;
        n_hold     = r_hold;
        n_armed    = r_armed;
        n_seg      = r_seg;
        push       = '0;
        if (i_adv && i_info.valid) begin
            if (i_info.tick) begin
                if (r_armed) begin
                    if (r_hold <= HOLD_W'(1)) begin
                        n_hold  = '0;
                        n_armed = 1'b0;
                        if (r_speaking) begin
                            push.n              = 2'd1;
                            push.r0.event_res   = (ms_cur < i_min_ms) ? EV_DISCARD : EV_COMMIT;
                            push.r0.segment_ms  = ms_cur;
                            push.r0.last_of_run = 1'b1;
                            n_speaking          = 1'b0;
                            n_seg               = '0;
                        end
                    end else begin
                        n_hold = r_hold - 1'b1;
                    end
                end
            end else if (i_info.voiced) begin
                n_hold                = i_hold_ms;
                n_armed               = 1'b1;
                push.r0.event_res     = r_speaking ? EV_APPEND : EV_START;
                push.r0.frame_samples = i_info.fs;
                push.r0.segment_ms    = ms_new;
                if (at_max) begin
                    // voiced frame reached max length: segment closes at once
                    push.n              = 2'd2;
                    push.r1.event_res   = (ms_new < i_min_ms) ? EV_DISCARD : EV_COMMIT;
                    push.r1.segment_ms  = ms_new;
                    push.r1.last_of_run = 1'b1;
                    n_speaking          = 1'b0;
                    n_seg               = '0;
                end else begin
                    push.n              = 2'd1;
                    push.r0.last_of_run = 1'b1;
                    n_speaking          = 1'b1;
                    n_seg               = seg_new;
                end
            end else if (r_speaking) begin
                push.n                = 2'd1;
                push.r0.event_res     = EV_TAIL;
                push.r0.frame_samples = i_info.fs;
                push.r0.segment_ms    = ms_new;
                push.r0.last_of_run   = 1'b1;
                n_seg                 = seg_new;
            end else begin
                push.n                = 2'd1;
                push.r0.event_res     = EV_DROP;
                push.r0.frame_samples = i_info.fs;
                push.r0.last_of_run   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speaking <= 1'b0;
            r_hold     <= '0;
            r_armed    <= 1'b0;
            r_seg      <= '0;
        end else begin
            r_speaking <= n_speaking;
            r_hold     <= n_hold;
            r_armed    <= n_armed;
            r_seg      <= n_seg;
        end
    end

    assign o_push = push;

endmodule

// ===== src/essp_out_fifo.sv =====
// Result buffer: takes up to two results a cycle, hands out one per transfer.
// Depends on essp_pkg.
module essp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  essp_pkg::t_push   i_push,
    input  logic              i_tready,
    output logic              o_tvalid,
    output essp_pkg::t_result o_data,
    output logic              o_room
);
    import essp_pkg::*;

    t_result               r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr, n_wr;
    logic [OUT_PTR_W-1:0]  r_rd, n_rd;
    logic [OUT_CNT_W-1:0]  r_cnt, n_cnt;
    logic [OUT_PTR_W-1:0]  wr_nxt;
    logic                  pop;

    assign o_tvalid = r_cnt != '0;
    assign pop      = o_tvalid && i_tready;
    assign o_data   = r_mem[r_rd];
    // room for a worst-case pair of results
    assign o_room   = r_cnt <= OUT_CNT_W'(OUT_DEPTH - 2);
    assign wr_nxt   = r_wr + OUT_PTR_W'(1);
    assign n_wr     = r_wr + OUT_PTR_W'(i_push.n);
    assign n_rd     = r_rd + OUT_PTR_W'(pop);
    assign n_cnt    = r_cnt + OUT_CNT_W'(i_push.n) - OUT_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_nxt] <= i_push.r1;
        end
    end

endmodule
